// File: sv/prq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the priority ready-queue scheduler.
// No dependencies; prq_cell and the top level import this package.
package prq_pkg;

  // Sizes of the task space and of the priority space.
  localparam int TASKS   = 16;
  localparam int LEVELS  = 32;
  localparam int TASK_W  = $clog2(TASKS);
  localparam int LEVEL_W = $clog2(LEVELS);

  // Fixed widths of the beat fields.
  localparam int TASK_ID_W = 4;
  localparam int PRIO_W    = 5;
  localparam int STATUS_W  = 2;

  // Command codes on the input channel.
  localparam logic CMD_ENQUEUE  = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  // Status codes on the result channel.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // Operations broadcast to the level cells.
  localparam logic [1:0] OP_NONE     = 2'd0;
  localparam logic [1:0] OP_ENQ      = 2'd1;
  localparam logic [1:0] OP_SET_HEAD = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  // Input beat.
  typedef struct packed {
    logic                 command;
    logic [TASK_ID_W-1:0] task_id;
    logic [PRIO_W-1:0]    priority_req;
  } prq_in_t;

  // Result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TASK_ID_W-1:0] chosen_task;
    logic [PRIO_W-1:0]    chosen_priority;
  } prq_out_t;

  // Command bus from the controller to every cell.
  typedef struct packed {
    logic [1:0]         op;
    logic [LEVEL_W-1:0] lvl;
    logic [TASK_W-1:0]  task_num;
  } cell_cmd_t;

  // Status a cell reports back to the controller.
  typedef struct packed {
    logic              occ;
    logic              hit;
    logic [TASK_W-1:0] head;
    logic [TASK_W-1:0] tail;
  } cell_stat_t;

endpackage

// File: sv/prq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the per-task link store.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/prq_cell.sv
`timescale 1ns / 1ps
// One priority level: occupancy bit, queue head and tail, and one stage of
// the search chain. Depends on prq_pkg.
module prq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [prq_pkg::LEVEL_W-1:0] level_idx,
  input  prq_pkg::cell_cmd_t          cmd,
  input  logic                        probe_in,
  output logic                        probe_out,
  output prq_pkg::cell_stat_t         stat
);
  import prq_pkg::*;

  logic              occ;
  logic [TASK_W-1:0] head;
  logic [TASK_W-1:0] tail;
  logic              sel;

  assign sel = (cmd.lvl == level_idx);

  // Occupancy bit and search token; an empty level passes the token on.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      probe_out <= 1'b0;
    end else begin
      probe_out <= probe_in & ~occ;
      if (sel) begin
        case (cmd.op)
          OP_ENQ:   occ <= 1'b1;
          OP_CLEAR: occ <= 1'b0;
          default:  ;
        endcase
      end
    end
  end

  // Queue head and tail of this level.
  always_ff @(posedge clk) begin
    if (sel) begin
      case (cmd.op)
        OP_ENQ: begin
          if (!occ) begin
            head <= cmd.task_num;
          end
          tail <= cmd.task_num;
        end
        OP_SET_HEAD: head <= cmd.task_num;
        default: ;
      endcase
    end
  end

  // The token stops at the first occupied level.
  assign stat.occ  = occ;
  assign stat.hit  = probe_in & occ;
  assign stat.head = head;
  assign stat.tail = tail;

endmodule

// File: sv/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Top level of the priority ready-queue scheduler: controller, row of level
// cells and link RAM. Depends on prq_pkg, prq_cell and prq_ram.
//
// One beat is worked at a time, and each beat gives exactly one result beat.
// An enqueue holds the input through S_ENQ and S_DONE. A schedule walks a
// search token down the row of level cells, one cell per cycle, starting at
// the most urgent level, and then passes through S_TAKE and S_DONE, or
// through S_DONE alone when no task is ready. A finished beat waits in
// S_DONE while an earlier result is still stalled at the output.
// The result sits in an output register, so a new beat is taken while an
// earlier result still waits. No clearing pass follows reset.
module priority_ready_queue_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  prq_pkg::prq_in_t  cmd_data,
  output logic              res_valid,
  input  logic              res_stall,
  output prq_pkg::prq_out_t res_data
);
  import prq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAKE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic               probe;
  logic [LEVELS:0]    probe_chain;
  cell_cmd_t          cell_cmd;
  cell_stat_t         stat [LEVELS];
  logic [TASK_W-1:0]  cur_task;
  logic [LEVEL_W-1:0] cur_lvl;
  logic [TASK_W-1:0]  cur_head;
  logic [TASK_W-1:0]  cur_tail;
  prq_out_t           res;
  logic               accept;
  logic               in_range;
  logic               hit_any;
  logic [LEVELS-1:0]  hit_vec;
  logic [LEVEL_W-1:0] sel_lvl;
  logic [TASK_W-1:0]  sel_head;
  logic [TASK_W-1:0]  sel_tail;
  logic               link_we;
  logic               link_re;
  logic [TASK_W-1:0]  link_rdata;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign in_range  = (int'(cmd_data.task_id) < TASKS) &&
                     (int'(cmd_data.priority_req) < LEVELS);

  // Row of level cells; the search token enters at the most urgent level.
  assign probe_chain[0] = probe;
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    prq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .level_idx (LEVEL_W'(i)),
      .cmd       (cell_cmd),
      .probe_in  (probe_chain[i]),
      .probe_out (probe_chain[i+1]),
      .stat      (stat[i])
    );
    assign hit_vec[i] = stat[i].hit;
  end

  // At most one cell hits; gather its level, head and tail.
  always_comb begin
    hit_any  = 1'b0;
    sel_lvl  = '0;
    sel_head = '0;
    sel_tail = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (stat[i].hit) begin
        hit_any  = 1'b1;
        sel_lvl  = sel_lvl | LEVEL_W'(i);
        sel_head = sel_head | stat[i].head;
        sel_tail = sel_tail | stat[i].tail;
      end
    end
  end

  // Link store: written on an enqueue behind an existing tail, read at the
  // head that a schedule is about to remove.
  assign link_we = (state == S_ENQ) && stat[cur_lvl].occ;
  assign link_re = (state == S_SCAN) && hit_any;

  prq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (TASKS)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (stat[cur_lvl].tail),
    .wdata (cur_task),
    .re    (link_re),
    .raddr (sel_head),
    .rdata (link_rdata)
  );

  // Command broadcast to the cells.
  always_comb begin
    cell_cmd.op       = OP_NONE;
    cell_cmd.lvl      = cur_lvl;
    cell_cmd.task_num = cur_task;
    case (state)
      S_ENQ: cell_cmd.op = OP_ENQ;
      S_TAKE: begin
        if (cur_head == cur_tail) begin
          cell_cmd.op = OP_CLEAR;
        end else begin
          cell_cmd.op       = OP_SET_HEAD;
          cell_cmd.task_num = link_rdata;
        end
      end
      default: ;
    endcase
  end

  // Controller state, search token and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      probe     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      probe <= 1'b0;
      // A result taken while the next one is finishing is replaced below.
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd_data.command == CMD_SCHEDULE) begin
              probe <= 1'b1;
              state <= S_SCAN;
            end else if (in_range) begin
              state <= S_ENQ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ENQ: state <= S_DONE;
        S_SCAN: begin
          if (hit_any) begin
            state <= S_TAKE;
          end else if (probe_chain[LEVELS]) begin
            state <= S_DONE;
          end
        end
        S_TAKE: state <= S_DONE;
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers and the result beat.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_task <= TASK_W'(cmd_data.task_id);
          cur_lvl  <= LEVEL_W'(cmd_data.priority_req);
          res      <= '{status: ST_ENQUEUED, chosen_task: '0, chosen_priority: '0};
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          cur_lvl  <= sel_lvl;
          cur_head <= sel_head;
          cur_tail <= sel_tail;
          res      <= '{status: ST_DEQUEUED,
                        chosen_task: TASK_ID_W'(sel_head),
                        chosen_priority: PRIO_W'(sel_lvl)};
        end else if (probe_chain[LEVELS]) begin
          res.status <= ST_EMPTY;
        end
      end
      S_DONE: begin
        if (!res_valid || !res_stall) begin
          res_data <= res;
        end
      end
      default: ;
    endcase
  end

  // Only one level can answer the search token.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one level cell hit");

  // A single search token travels the chain.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(probe_chain))
    else $error("more than one search token in the cell chain");

  // Cells answer only while the controller is searching.
  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    hit_any |-> (state == S_SCAN))
    else $error("cell hit outside of a search");

  // The level being dequeued is still marked occupied.
  a_take_occupied: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> stat[cur_lvl].occ)
    else $error("dequeue from an empty level");

endmodule
